>>> design/tbwd_pkg.sv
// Package for the two-by-one word divider: field widths, status codes,
// transaction structs and the per-stage control struct.
// No dependencies; every design file refers to it by scoped names.
package tbwd_pkg;

    localparam int WORD_MAX = 64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [WORD_MAX-1:0] numerator_high;
        logic [WORD_MAX-1:0] numerator_low;
        logic [WORD_MAX-1:0] divisor;
    } in_t;

    typedef struct packed {
        logic [WORD_MAX-1:0] quotient;
        logic [WORD_MAX-1:0] remainder;
        status_t             status;
    } out_t;

    // Control that rides along with the data through every stage.
    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

endpackage

>>> design/tbwd_front.sv
// Entry stage of the divider: trims operands to the word width, classifies
// divide-by-zero and overflow, and registers the first pipeline stage.
// Depends on tbwd_pkg.
module tbwd_front #(
    parameter int WORD_BITS = tbwd_pkg::WORD_MAX
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  tbwd_pkg::in_t        operands,
    output tbwd_pkg::ctl_t       ctl,
    output logic [WORD_BITS-1:0] rem,
    output logic [WORD_BITS-1:0] qlo,
    output logic [WORD_BITS-1:0] dvs
);

    tbwd_pkg::ctl_t        ctl_reg;
    tbwd_pkg::ctl_t        ctl_next;
    logic [WORD_BITS-1:0]  hi_w;
    logic [WORD_BITS-1:0]  lo_w;
    logic [WORD_BITS-1:0]  d_w;
    logic [WORD_BITS-1:0]  rem_reg;
    logic [WORD_BITS-1:0]  qlo_reg;
    logic [WORD_BITS-1:0]  dvs_reg;

    assign hi_w = operands.numerator_high[WORD_BITS-1:0];
    assign lo_w = operands.numerator_low[WORD_BITS-1:0];
    assign d_w  = operands.divisor[WORD_BITS-1:0];

    always_comb
    begin
        ctl_next.valid = take;
        if (d_w == '0)
        begin
            ctl_next.status = tbwd_pkg::ST_DIV_ZERO;
        end
        else if (hi_w >= d_w)
        begin
            ctl_next.status = tbwd_pkg::ST_OVERFLOW;
        end
        else
        begin
            ctl_next.status = tbwd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, status: tbwd_pkg::ST_OK};
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= hi_w;
        qlo_reg <= lo_w;
        dvs_reg <= d_w;
    end

    assign ctl = ctl_reg;
    assign rem = rem_reg;
    assign qlo = qlo_reg;
    assign dvs = dvs_reg;

endmodule

>>> design/tbwd_stage.sv
// One restoring-division step: shift in the next numerator bit, trial
// subtract the divisor, retire one quotient bit. Depends on tbwd_pkg.
module tbwd_stage #(
    parameter int WORD_BITS = tbwd_pkg::WORD_MAX
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbwd_pkg::ctl_t       ctl_in,
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [WORD_BITS-1:0] qlo_in,
    input  logic [WORD_BITS-1:0] dvs_in,
    output tbwd_pkg::ctl_t       ctl_out,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [WORD_BITS-1:0] qlo_out,
    output logic [WORD_BITS-1:0] dvs_out
);

    tbwd_pkg::ctl_t        ctl_reg;
    logic [WORD_BITS-1:0]  rem_reg;
    logic [WORD_BITS-1:0]  rem_next;
    logic [WORD_BITS-1:0]  qlo_reg;
    logic [WORD_BITS-1:0]  qlo_next;
    logic [WORD_BITS-1:0]  dvs_reg;
    logic [WORD_BITS:0]    shifted;
    logic [WORD_BITS:0]    diff;
    logic                  take_bit;

    // qlo holds the unconsumed numerator bits on top and the quotient
    // bits found so far at the bottom; it shifts left by one per stage.
    always_comb
    begin
        shifted  = {rem_in, qlo_in[WORD_BITS-1]};
        diff     = shifted - {1'b0, dvs_in};
        take_bit = ~diff[WORD_BITS];
        rem_next = take_bit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        qlo_next = {qlo_in[WORD_BITS-2:0], take_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, status: tbwd_pkg::ST_OK};
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qlo_reg <= qlo_next;
        dvs_reg <= dvs_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign qlo_out = qlo_reg;
    assign dvs_out = dvs_reg;

endmodule

>>> design/two_by_one_word_divider.sv
// Two-by-one word divider: entry register, WORD_BITS step stages, then the
// done register; one transaction per cycle sustained; busy never rises.
// Depth is set by the chain of WORD_BITS one-bit trial-subtract stages.
// Reset (rst_n low, asynchronous) clears only the control and done registers;
// the receiver cannot stall, so nothing in the pipeline ever holds.
// Depends on tbwd_pkg, tbwd_front and tbwd_stage.
module two_by_one_word_divider #(
    parameter int WORD_BITS = tbwd_pkg::WORD_MAX
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tbwd_pkg::in_t  operands,
    output logic           done,
    output tbwd_pkg::out_t result
);

    localparam int WM = tbwd_pkg::WORD_MAX;

    // Stage taps: index 0 is the entry register, index WORD_BITS the last step.
    tbwd_pkg::ctl_t        ctl_chain [WORD_BITS+1];
    logic [WORD_BITS-1:0]  rem_chain [WORD_BITS+1];
    logic [WORD_BITS-1:0]  qlo_chain [WORD_BITS+1];
    logic [WORD_BITS-1:0]  dvs_chain [WORD_BITS+1];

    logic                  done_reg;
    tbwd_pkg::out_t        result_reg;
    tbwd_pkg::out_t        result_next;
    logic                  take;

    // The pipeline never stops, so a transaction is taken whenever start is high.
    assign busy = 1'b0;
    assign take = start & ~busy;

    // Trim operands, classify error cases, register stage 0.
    tbwd_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .operands (operands),
        .ctl      (ctl_chain[0]),
        .rem      (rem_chain[0]),
        .qlo      (qlo_chain[0]),
        .dvs      (dvs_chain[0])
    );

    // One quotient bit per stage, most significant first. Error transactions
    // flow through too; their data is dropped at the output.
    for (genvar s = 0; s < WORD_BITS; s++)
    begin : g_stage
        tbwd_stage #(
            .WORD_BITS (WORD_BITS)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[s]),
            .rem_in  (rem_chain[s]),
            .qlo_in  (qlo_chain[s]),
            .dvs_in  (dvs_chain[s]),
            .ctl_out (ctl_chain[s+1]),
            .rem_out (rem_chain[s+1]),
            .qlo_out (qlo_chain[s+1]),
            .dvs_out (dvs_chain[s+1])
        );
    end

    // Zero the data on any error status; widen to the port word.
    always_comb
    begin
        result_next.status = ctl_chain[WORD_BITS].status;
        if (ctl_chain[WORD_BITS].status == tbwd_pkg::ST_OK)
        begin
            result_next.quotient  = WM'(qlo_chain[WORD_BITS]);
            result_next.remainder = WM'(rem_chain[WORD_BITS]);
        end
        else
        begin
            result_next.quotient  = '0;
            result_next.remainder = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_chain[WORD_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> dv/two_by_one_word_divider_test.sv
// Self-checking testbench for two_by_one_word_divider: drives divide transactions
// through the start/busy handshake and checks every done strobe against a prediction.
// Depends on tbwd_pkg and the two_by_one_word_divider RTL.
module two_by_one_word_divider_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS   = tbwd_pkg::WORD_MAX;
    // The pipeline is WORD_BITS + 2 deep. Allow for that, for the longest
    // sender gap and for the final settle, many times over.
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [WORD_BITS-1:0] TOP_BIT  = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    tbwd_pkg::in_t  operands;
    logic           done;
    tbwd_pkg::out_t result;

    // Quotient/remainder/status predictions for accepted transactions, oldest first.
    tbwd_pkg::out_t pending_results[$];
    int             failures;

    two_by_one_word_divider #(
        .WORD_BITS(WORD_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Exact two-word by one-word division. Divide-by-zero wins over overflow,
    // and both leave quotient and remainder at zero.
    function automatic tbwd_pkg::out_t predict_division(tbwd_pkg::in_t op);
        logic [2*WORD_BITS-1:0] dividend;
        logic [2*WORD_BITS-1:0] wide_divisor;
        tbwd_pkg::out_t answer;
        answer        = '0;
        answer.status = tbwd_pkg::ST_OK;
        if (op.divisor == '0)
        begin
            answer.status = tbwd_pkg::ST_DIV_ZERO;
        end
        else if (op.numerator_high >= op.divisor)
        begin
            answer.status = tbwd_pkg::ST_OVERFLOW;
        end
        else
        begin
            dividend         = {op.numerator_high, op.numerator_low};
            wide_divisor     = {{WORD_BITS{1'b0}}, op.divisor};
            answer.quotient  = WORD_BITS'(dividend / wide_divisor);
            answer.remainder = WORD_BITS'(dividend % wide_divisor);
        end
        return answer;
    endfunction

    function automatic logic [WORD_BITS-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Pick operands by class: mostly legal divisions over a spread of divisor
    // magnitudes, plus a share of divide-by-zero and quotient overflow.
    function automatic tbwd_pkg::in_t random_operands();
        tbwd_pkg::in_t op;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            op.divisor = '0;
        else if (pick < 12)
            op.divisor = {{(WORD_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_BITS-1);
        else if (pick < 25)
            op.divisor = WORD_BITS'($urandom_range(1, 65535));
        else if (pick < 37)
            op.divisor = random_word() | TOP_BIT;
        else if (pick < 42)
            op.divisor = ALL_ONES;
        else
            op.divisor = random_word() >> $urandom_range(0, WORD_BITS-1);
        if (op.divisor == '0 && pick >= 5)
            op.divisor = WORD_BITS'(1);

        pick = $urandom_range(0, 99);
        if (op.divisor == '0)
            op.numerator_high = random_word();
        else if (pick < 8)
            op.numerator_high = op.divisor | random_word();
        else if (pick < 18)
            op.numerator_high = op.divisor - 1;
        else if (pick < 26)
            op.numerator_high = '0;
        else
            op.numerator_high = random_word() % op.divisor;

        pick = $urandom_range(0, 99);
        if (pick < 8)
            op.numerator_low = '0;
        else if (pick < 16)
            op.numerator_low = ALL_ONES;
        else
            op.numerator_low = random_word();
        return op;
    endfunction

    // Present one transaction and hold it until the divider takes it.
    // Start stays high on return so back-to-back sends need not raise it again.
    task automatic send_division(input tbwd_pkg::in_t op);
        start    <= 1'b1;
        operands <= op;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_operands(input logic [WORD_BITS-1:0] high,
                                 input logic [WORD_BITS-1:0] low,
                                 input logic [WORD_BITS-1:0] div);
        tbwd_pkg::in_t op;
        op.numerator_high = high;
        op.numerator_low  = low;
        op.divisor        = div;
        send_division(op);
    endtask

    // Random idle time between transactions: mostly none or short, a few long.
    // Scramble the operands while start is low; the divider must ignore them.
    task automatic idle_gap();
        int pick;
        int cycles;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            cycles = 0;
        else if (pick < 90)
            cycles = $urandom_range(1, 3);
        else
            cycles = $urandom_range(10, 40);
        if (cycles > 0)
        begin
            start    <= 1'b0;
            operands <= {random_word(), random_word(), random_word()};
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_divide_by_zero();
        send_operands('0, '0, '0);
        idle_gap();
        send_operands(ALL_ONES, ALL_ONES, '0);
        idle_gap();
        send_operands(random_word(), random_word(), '0);
        idle_gap();
    endtask

    task automatic test_quotient_overflow();
        send_operands(5, '0, 5);
        send_operands(ALL_ONES, '0, 1);
        send_operands(ALL_ONES, ALL_ONES, ALL_ONES);
        idle_gap();
        send_operands(TOP_BIT, random_word(), TOP_BIT - 1);
        idle_gap();
    endtask

    task automatic test_word_extremes();
        send_operands('0, '0, 1);
        send_operands('0, ALL_ONES, 1);
        send_operands('0, ALL_ONES, ALL_ONES);
        send_operands(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        idle_gap();
        send_operands(ALL_ONES - 1, '0, ALL_ONES);
        send_operands(TOP_BIT - 1, ALL_ONES, TOP_BIT);
        send_operands('0, '0, ALL_ONES);
        idle_gap();
        send_operands('0, 1, 2);
        send_operands(1, '0, 2);
        send_operands({(WORD_BITS/2){2'b01}}, {(WORD_BITS/2){2'b10}},
                      {(WORD_BITS/2){2'b10}});
        idle_gap();
    endtask

    // Sustained one-per-cycle stream with no idle cycles at all.
    task automatic test_back_to_back();
        repeat (60) send_division(random_operands());
    endtask

    // Stop mid-stream until the pipeline is empty, then resume.
    task automatic test_drain_pause();
        repeat (20)
        begin
            send_division(random_operands());
            idle_gap();
        end
        drain_results();
        repeat (20)
        begin
            send_division(random_operands());
            idle_gap();
        end
    endtask

    task automatic test_random_divisions();
        repeat (800)
        begin
            send_division(random_operands());
            idle_gap();
        end
    endtask

    // Scoreboard: check the done strobe first, since a result leaving and a
    // transaction entering at one edge belong to different items.
    always @(posedge clk)
    begin
        tbwd_pkg::out_t want;
        if (done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result q=%h r=%h status=%0d",
                             $realtime, result.quotient, result.remainder, result.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.quotient !== want.quotient ||
                    result.remainder !== want.remainder ||
                    result.status !== want.status)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: expected q=%h r=%h st=%0d got q=%h r=%h st=%0d",
                                 $realtime, want.quotient, want.remainder, want.status,
                                 result.quotient, result.remainder, result.status);
                end
            end
        end
        if (rst_n && start && !busy)
            pending_results.push_back(predict_division(operands));
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        failures = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        operands = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_divide_by_zero();
        test_quotient_overflow();
        test_word_extremes();
        test_back_to_back();
        test_drain_pause();
        test_random_divisions();

        // Let the pipeline empty, then watch a little longer for stray strobes.
        drain_results();
        repeat (WORD_BITS + 10) @(posedge clk);

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
